// File: rtl/cdr_pkg.sv
// shared types, constants and byte tables for the captive portal dns responder
package cdr_pkg;

  localparam int unsigned MaxDatagram = 512;
  localparam int unsigned HeaderLen   = 12;
  localparam int unsigned AnswerLen   = 16;
  localparam int unsigned QtailLen    = 5;

  localparam int unsigned PosW  = $clog2(MaxDatagram + 1);
  localparam int unsigned LabW  = $clog2(MaxDatagram + 256 + 1);
  localparam int unsigned CmpW  = LabW + 1;
  localparam int unsigned AnsIdxW = $clog2(AnswerLen);

  localparam logic [7:0] FlagsHi   = 8'h81;
  localparam logic [7:0] FlagsLo   = 8'h80;
  localparam logic [7:0] PtrHi     = 8'hC0;
  localparam logic [7:0] PtrLo     = 8'h0C;
  localparam logic [7:0] RdLen     = 8'h04;
  localparam logic [7:0] TypeA     = 8'h01;
  localparam logic [7:0] ClassIn   = 8'h01;

  typedef enum logic [1:0] {
    REG_ADDRESS = 2'd0,
    REG_TTL     = 2'd1
  } cfg_reg_e;

  localparam logic [31:0] AddressReset = 32'hC0A8_0901;
  localparam logic [31:0] TtlReset     = 32'd60;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       rx_last;
  } rx_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_last;
    logic       tx_drop;
  } tx_item_t;

  typedef struct packed {
    logic       valid;
    logic       last;
    logic       ok;
    logic       echo;
    logic [7:0] echo_byte;
  } evt_t;

  function automatic logic [7:0] header_byte(logic [3:0] idx, logic [7:0] b);
    logic [7:0] r;
    r = b;
    case (idx)
      4'd2:    r = FlagsHi;
      4'd3:    r = FlagsLo;
      4'd6:    r = 8'h00;
      4'd7:    r = 8'h01;
      4'd8, 4'd9, 4'd10, 4'd11: r = 8'h00;
      default: r = b;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] answer_byte(logic [AnsIdxW-1:0] idx,
                                             logic [31:0] ttl,
                                             logic [31:0] addr);
    logic [7:0] r;
    r = 8'h00;
    case (idx)
      4'd0:    r = PtrHi;
      4'd1:    r = PtrLo;
      4'd2:    r = 8'h00;
      4'd3:    r = TypeA;
      4'd4:    r = 8'h00;
      4'd5:    r = ClassIn;
      4'd6:    r = ttl[31:24];
      4'd7:    r = ttl[23:16];
      4'd8:    r = ttl[15:8];
      4'd9:    r = ttl[7:0];
      4'd10:   r = 8'h00;
      4'd11:   r = RdLen;
      4'd12:   r = addr[31:24];
      4'd13:   r = addr[23:16];
      4'd14:   r = addr[15:8];
      4'd15:   r = addr[7:0];
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/cdr_parser.sv
// input register and question parser that tracks header, name labels and checks
module cdr_parser import cdr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     rx_valid_i,
  input  rx_item_t rx_i,
  output logic     rx_stall_o,
  output evt_t     evt_o,
  input  logic     evt_take_i
);

  logic            in_valid_q, in_valid_d;
  rx_item_t        in_q;
  logic [PosW-1:0] pos_q, pos_d;
  logic [LabW-1:0] next_lab_q, next_lab_d;
  logic            name_done_q, name_done_d;
  logic [LabW-1:0] qend_q, qend_d;

  logic            in_range, is_header, at_label;
  logic [PosW-1:0] len;
  logic            ok;

  assign rx_stall_o = in_valid_q && !evt_take_i;

  always_comb begin
    in_range    = pos_q < PosW'(MaxDatagram);
    is_header   = pos_q < PosW'(HeaderLen);
    at_label    = !name_done_q && (LabW'(pos_q) == next_lab_q);
    next_lab_d  = next_lab_q;
    name_done_d = name_done_q;
    qend_d      = qend_q;
    evt_o.echo      = 1'b0;
    evt_o.echo_byte = in_q.rx_byte;
    if (in_range) begin
      if (is_header) begin
        evt_o.echo      = 1'b1;
        evt_o.echo_byte = header_byte(pos_q[3:0], in_q.rx_byte);
      end else begin
        if (at_label) begin
          if (in_q.rx_byte == 8'h00) begin
            name_done_d = 1'b1;
            qend_d      = LabW'(pos_q) + LabW'(QtailLen);
          end else begin
            next_lab_d = LabW'(pos_q) + LabW'(in_q.rx_byte) + LabW'(1);
          end
        end
        evt_o.echo = !name_done_d || (LabW'(pos_q) < qend_d);
      end
      pos_d = pos_q + PosW'(1);
    end else begin
      pos_d = pos_q;
    end
    len = pos_d;
    ok  = (len >= PosW'(HeaderLen)) && name_done_d && (qend_d <= LabW'(len)) &&
          (CmpW'(qend_d) + CmpW'(AnswerLen) <= CmpW'(MaxDatagram));
    evt_o.valid = in_valid_q;
    evt_o.last  = in_q.rx_last;
    evt_o.ok    = ok;
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (!rx_stall_o) begin
      in_valid_d = rx_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      pos_q       <= '0;
      next_lab_q  <= LabW'(HeaderLen);
      name_done_q <= 1'b0;
      qend_q      <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      if (in_valid_q && evt_take_i) begin
        if (in_q.rx_last) begin
          pos_q       <= '0;
          next_lab_q  <= LabW'(HeaderLen);
          name_done_q <= 1'b0;
          qend_q      <= '0;
        end else begin
          pos_q       <= pos_d;
          next_lab_q  <= next_lab_d;
          name_done_q <= name_done_d;
          qend_q      <= qend_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!rx_stall_o && rx_valid_i) begin
      in_q <= rx_i;
    end
  end

endmodule

// File: rtl/cdr_tx.sv
// result register and answer record sequencer
module cdr_tx import cdr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  evt_t        evt_i,
  output logic        evt_take_o,
  input  logic [31:0] ttl_i,
  input  logic [31:0] addr_i,
  output logic        tx_valid_o,
  output tx_item_t    tx_o,
  input  logic        tx_stall_i
);

  logic               out_valid_q, out_valid_d;
  tx_item_t           out_q, out_d;
  logic               burst_q, burst_d;
  logic [AnsIdxW-1:0] cnt_q, cnt_d;
  logic               out_free;

  assign out_free   = !out_valid_q || !tx_stall_i;
  assign evt_take_o = evt_i.valid && out_free && !burst_q;
  assign tx_valid_o = out_valid_q;
  assign tx_o       = out_q;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    burst_d     = burst_q;
    cnt_d       = cnt_q;
    if (out_free) begin
      out_valid_d = 1'b0;
      if (burst_q) begin
        out_valid_d   = 1'b1;
        out_d.tx_byte = answer_byte(cnt_q, ttl_i, addr_i);
        out_d.tx_last = (cnt_q == AnsIdxW'(AnswerLen - 1));
        out_d.tx_drop = 1'b0;
        cnt_d         = cnt_q + AnsIdxW'(1);
        if (cnt_q == AnsIdxW'(AnswerLen - 1)) begin
          burst_d = 1'b0;
        end
      end else if (evt_i.valid) begin
        if (evt_i.last && !evt_i.ok) begin
          out_valid_d = 1'b1;
          out_d       = '{tx_byte: 8'h00, tx_last: 1'b1, tx_drop: 1'b1};
        end else if (evt_i.echo) begin
          out_valid_d = 1'b1;
          out_d       = '{tx_byte: evt_i.echo_byte, tx_last: 1'b0, tx_drop: 1'b0};
          if (evt_i.last) begin
            burst_d = 1'b1;
            cnt_d   = '0;
          end
        end else if (evt_i.last) begin
          out_valid_d = 1'b1;
          out_d       = '{tx_byte: answer_byte('0, ttl_i, addr_i), tx_last: 1'b0,
                          tx_drop: 1'b0};
          burst_d     = 1'b1;
          cnt_d       = AnsIdxW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      burst_q     <= 1'b0;
      cnt_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      burst_q     <= burst_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

`ifndef SYNTH
  a_drop_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_valid_o && tx_o.tx_drop |-> tx_o.tx_last)
    else $error("drop flag on a non-final item");

  a_no_take_in_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    burst_q |-> !evt_take_o)
    else $error("input taken during answer burst");

  a_burst_ends_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_free && burst_q && (cnt_q == AnsIdxW'(AnswerLen - 1))
      |=> tx_valid_o && tx_o.tx_last && !burst_q)
    else $error("answer burst did not close with final item");
`endif

endmodule

// File: rtl/captive_dns_responder.sv
// captive portal dns responder top level with configuration registers
// Takes one query byte per cycle while not stalled and produces the rewritten
// response stream; an accepted byte passes the parser input register and the
// result register before its echo. Every good datagram's last byte adds
// sixteen answer items, one per cycle from the answer sequencer while the
// output is not stalled, and input stalls while they go out. Non-final bytes
// with no echo produce nothing. Configuration writes are always ready and are
// meant to land while no datagram is in flight. No clearing pass after reset.
module captive_dns_responder import cdr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_valid_i,
  input  rx_item_t    rx_i,
  output logic        rx_stall_o,
  output logic        tx_valid_o,
  output tx_item_t    tx_o,
  input  logic        tx_stall_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic [31:0] addr_q, ttl_q;
  evt_t        evt;
  logic        evt_take;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= AddressReset;
      ttl_q  <= TtlReset;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_ADDRESS: addr_q <= cfg_data_i;
        REG_TTL:     ttl_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cdr_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_i       (rx_i),
    .rx_stall_o (rx_stall_o),
    .evt_o      (evt),
    .evt_take_i (evt_take)
  );

  cdr_tx u_tx (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .evt_i      (evt),
    .evt_take_o (evt_take),
    .ttl_i      (ttl_q),
    .addr_i     (addr_q),
    .tx_valid_o (tx_valid_o),
    .tx_o       (tx_o),
    .tx_stall_i (tx_stall_i)
  );

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the captive portal dns responder
module tb;
  import cdr_pkg::*;

  localparam int unsigned IdleLimit    = 3000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned PhaseItems   = 60;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  typedef struct packed {
    rx_item_t rx;
    logic     typed;
    tx_item_t want;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        rx_valid_i;
  rx_item_t    rx_i;
  logic        rx_stall_o;
  logic        tx_valid_o;
  tx_item_t    tx_o;
  logic        tx_stall_i = 1'b0;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  int unsigned dg_pos;
  int unsigned label_at;
  int unsigned q_end;
  bit          name_done;
  logic [31:0] cur_addr;
  logic [31:0] cur_ttl;
  tx_item_t    response_q[$];

  int unsigned bytes_taken = 0;
  int unsigned cfg_done    = 0;
  int unsigned errors      = 0;
  int unsigned idle_cycles = 0;
  bit          row_typed;
  tx_item_t    row_want;
  int unsigned burst_left;
  int unsigned gap_max;
  logic [7:0]  dg[$];
  int unsigned stall_tick  = 0;
  stall_mode_e stall_mode  = STALL_NONE;

  captive_dns_responder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_valid_i  (rx_valid_i),
    .rx_i        (rx_i),
    .rx_stall_o  (rx_stall_o),
    .tx_valid_o  (tx_valid_o),
    .tx_o        (tx_o),
    .tx_stall_i  (tx_stall_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void clear_query_state();
    dg_pos    = 0;
    label_at  = HeaderLen;
    name_done = 1'b0;
    q_end     = 0;
  endfunction

  function automatic stim_row_t dir_row(logic [7:0] b, logic l, logic typed,
                                        logic [7:0] eb, logic el, logic ed);
    stim_row_t r;
    r.rx    = '{b, l};
    r.typed = typed;
    r.want  = '{eb, el, ed};
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    errors++;
    $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  task automatic predict_response(rx_item_t it, bit typed, tx_item_t typed_want);
    tx_item_t    made[$];
    logic [7:0]  answer [16];
    logic [7:0]  echo_b;
    bit          echo;
    bit          ok;
    int unsigned p;
    echo   = 1'b0;
    echo_b = 8'h00;
    if (dg_pos < MaxDatagram) begin
      p = dg_pos;
      if (p < HeaderLen) begin
        echo = 1'b1;
        case (p)
          2: echo_b = FlagsHi;
          3: echo_b = FlagsLo;
          7: echo_b = 8'h01;
          6, 8, 9, 10, 11: echo_b = 8'h00;
          default: echo_b = it.rx_byte;
        endcase
      end else begin
        if (!name_done && p == label_at) begin
          if (it.rx_byte == 8'h00) begin
            name_done = 1'b1;
            q_end     = p + QtailLen;
          end else begin
            label_at = p + it.rx_byte + 1;
          end
        end
        if (!name_done || p < q_end) begin
          echo   = 1'b1;
          echo_b = it.rx_byte;
        end
      end
      dg_pos = p + 1;
    end
    if (echo) made.push_back('{echo_b, 1'b0, 1'b0});
    if (it.rx_last) begin
      ok = dg_pos >= HeaderLen && name_done && q_end <= dg_pos &&
           q_end + AnswerLen <= MaxDatagram;
      if (!ok) begin
        made.delete();
        made.push_back('{8'h00, 1'b1, 1'b1});
      end else begin
        answer = '{PtrHi, PtrLo, 8'h00, TypeA, 8'h00, ClassIn,
                   cur_ttl[31:24], cur_ttl[23:16], cur_ttl[15:8], cur_ttl[7:0],
                   8'h00, RdLen,
                   cur_addr[31:24], cur_addr[23:16], cur_addr[15:8], cur_addr[7:0]};
        foreach (answer[i]) made.push_back('{answer[i], (i == 15), 1'b0});
      end
      clear_query_state();
    end
    if (typed) begin
      response_q.push_back(typed_want);
    end else begin
      foreach (made[i]) response_q.push_back(made[i]);
    end
  endtask

  always @(posedge clk_i) begin
    tx_item_t want;
    logic     moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        moved = 1'b1;
        cfg_done++;
        case (cfg_index_i)
          REG_ADDRESS: cur_addr = cfg_data_i;
          REG_TTL:     cur_ttl = cfg_data_i;
          default: ;
        endcase
      end
      if (rx_valid_i && !rx_stall_o) begin
        moved = 1'b1;
        predict_response(rx_i, row_typed, row_want);
        bytes_taken++;
      end
      if (tx_valid_o && !tx_stall_i) begin
        moved = 1'b1;
        if (response_q.size() == 0) begin
          report_mismatch("unexpected response item", tx_o.tx_byte, 0);
        end else begin
          want = response_q.pop_front();
          if (tx_o.tx_byte !== want.tx_byte)
            report_mismatch("tx_byte", tx_o.tx_byte, want.tx_byte);
          if (tx_o.tx_last !== want.tx_last)
            report_mismatch("tx_last", tx_o.tx_last, want.tx_last);
          if (tx_o.tx_drop !== want.tx_drop)
            report_mismatch("tx_drop", tx_o.tx_drop, want.tx_drop);
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_tick % 48 == 0) stall_mode = stall_mode_e'($urandom_range(3, 0));
    stall_tick++;
    case (stall_mode)
      STALL_NONE:  tx_stall_i <= 1'b0;
      STALL_LIGHT: tx_stall_i <= ($urandom_range(3, 0) == 0);
      STALL_HEAVY: tx_stall_i <= ($urandom_range(3, 0) != 0);
      default:     tx_stall_i <= (stall_tick % 7 < 3);
    endcase
  end

  task automatic send_byte(rx_item_t it, bit typed, tx_item_t want);
    int unsigned gap;
    int unsigned target;
    if (burst_left == 0) begin
      gap        = $urandom_range(gap_max, 0);
      burst_left = $urandom_range(24, 1);
      if (gap != 0) begin
        rx_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    row_typed = typed;
    row_want  = want;
    rx_i       <= it;
    rx_valid_i <= 1'b1;
    target = bytes_taken + 1;
    do @(negedge clk_i); while (bytes_taken != target);
  endtask

  task automatic send_datagram();
    rx_item_t it;
    foreach (dg[i]) begin
      it.rx_byte = dg[i];
      it.rx_last = (i == dg.size() - 1);
      send_byte(it, 1'b0, '0);
    end
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] value);
    int unsigned target;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    target = cfg_done + 1;
    do @(negedge clk_i); while (cfg_done != target);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // wait until every response item is out and the block has gone quiet
  task automatic settle();
    rx_valid_i <= 1'b0;
    burst_left = 0;
    while (response_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // header, name of name_len bytes in labels, zero label, qtype, qclass, tail
  task automatic build_query(int unsigned name_len, int unsigned max_lab,
                             int unsigned tail);
    int unsigned rem;
    int unsigned lab;
    int unsigned lab_hi;
    dg.delete();
    repeat (HeaderLen) dg.push_back(8'($urandom_range(255, 0)));
    rem = name_len;
    while (rem != 0) begin
      lab_hi = (rem - 1 < max_lab) ? rem - 1 : max_lab;
      lab    = $urandom_range(lab_hi, 1);
      if (rem - lab - 1 == 1) lab = (lab > 1) ? lab - 1 : lab + 1;
      dg.push_back(lab[7:0]);
      repeat (lab) dg.push_back(8'($urandom_range(255, 0)));
      rem -= lab + 1;
    end
    dg.push_back(8'h00);
    repeat (QtailLen - 1 + tail) dg.push_back(8'($urandom_range(255, 0)));
  endtask

  initial begin
    stim_row_t   dir_rows[$];
    int unsigned phase_start;
    int unsigned pick;
    int unsigned name_len;
    int unsigned cut;
    rst_ni      = 1'b0;
    rx_valid_i  = 1'b0;
    rx_i        = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_ADDRESS;
    cfg_data_i  = '0;
    row_typed   = 1'b0;
    row_want    = '0;
    burst_left  = 0;
    gap_max     = 4;
    cur_addr    = AddressReset;
    cur_ttl     = TtlReset;
    clear_query_state();
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // minimal good query, header rewrite and a bare question
    dir_rows.push_back(dir_row(8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0));
    dir_rows.push_back(dir_row(8'hFF, 1'b0, 1'b1, 8'hFF, 1'b0, 1'b0));
    dir_rows.push_back(dir_row(8'hFF, 1'b0, 1'b1, FlagsHi, 1'b0, 1'b0));
    dir_rows.push_back(dir_row(8'h00, 1'b0, 1'b1, FlagsLo, 1'b0, 1'b0));
    dir_rows.push_back(dir_row(8'hFF, 1'b0, 1'b1, 8'hFF, 1'b0, 1'b0));
    dir_rows.push_back(dir_row(8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0));
    dir_rows.push_back(dir_row(8'hFF, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0));
    dir_rows.push_back(dir_row(8'h00, 1'b0, 1'b1, 8'h01, 1'b0, 1'b0));
    dir_rows.push_back(dir_row(8'hFF, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0));
    dir_rows.push_back(dir_row(8'hFF, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0));
    dir_rows.push_back(dir_row(8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0));
    dir_rows.push_back(dir_row(8'hFF, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0));
    dir_rows.push_back(dir_row(8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0));
    dir_rows.push_back(dir_row(8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0));
    dir_rows.push_back(dir_row(8'h01, 1'b0, 1'b1, 8'h01, 1'b0, 1'b0));
    dir_rows.push_back(dir_row(8'hFF, 1'b0, 1'b1, 8'hFF, 1'b0, 1'b0));
    // last byte inside the question: echo plus answer record
    dir_rows.push_back(dir_row(8'hFF, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0));
    // one byte datagram, then a two byte one: both too short
    dir_rows.push_back(dir_row(8'h00, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1));
    dir_rows.push_back(dir_row(8'hFF, 1'b0, 1'b1, 8'hFF, 1'b0, 1'b0));
    dir_rows.push_back(dir_row(8'hFF, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1));
    foreach (dir_rows[i]) send_byte(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].want);

    // question ending exactly at the answer room limit, then one past it
    build_query(479, 63, 0);
    send_datagram();
    build_query(480, 63, 0);
    send_datagram();
    // oversize datagram with a good question
    build_query(20, 63, 493);
    send_datagram();
    // oversize datagram whose name never ends inside the limit
    build_query(600, 63, 0);
    while (dg.size() > 520) void'(dg.pop_back());
    send_datagram();

    for (int phase = 0; phase < 5; phase++) begin
      settle();
      case (phase)
        1: begin
          write_reg(REG_ADDRESS, 32'h0000_0000);
          write_reg(REG_TTL, 32'h0000_0000);
          gap_max = 0;
        end
        2: begin
          write_reg(REG_TTL, 32'hFFFF_FFFF);
          write_reg(REG_ADDRESS, 32'hFFFF_FFFF);
          gap_max = 12;
        end
        3, 4: begin
          write_reg(REG_ADDRESS, $urandom);
          write_reg(REG_TTL, $urandom);
          gap_max = (phase == 3) ? 3 : 8;
        end
        default: gap_max = 5;
      endcase
      phase_start = bytes_taken;
      while (bytes_taken - phase_start < PhaseItems) begin
        pick     = $urandom_range(99, 0);
        name_len = $urandom_range(40, 1);
        if (name_len == 1) name_len = 0;
        if (pick < 50) begin
          build_query(name_len, 63, $urandom_range(6, 0));
        end else if (pick < 55) begin
          // labels of up to 255 bytes, so the top length bits can be set
          build_query($urandom_range(256, 64), 255, $urandom_range(3, 0));
        end else if (pick < 72) begin
          // cut off before the question ends
          build_query(name_len, 63, 0);
          cut = $urandom_range(HeaderLen + name_len + QtailLen - 1, 1);
          while (dg.size() > cut) void'(dg.pop_back());
        end else if (pick < 84) begin
          dg.delete();
          repeat ($urandom_range(42, 13)) dg.push_back(8'($urandom_range(255, 0)));
        end else if (pick < 93) begin
          build_query(0, 63, 0);
        end else begin
          dg.delete();
          repeat ($urandom_range(11, 1)) dg.push_back(8'($urandom_range(255, 0)));
        end
        send_datagram();
      end
    end

    settle();
    if (response_q.size() != 0) report_mismatch("items never delivered", response_q.size(), 0);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
